### hdl/bpc_pkg.sv
package bpc_pkg;

	localparam logic [2:0] REG_AC1_AC2_AC3 = 3'd0;
	localparam logic [2:0] REG_AC4_AC5_AC6 = 3'd1;
	localparam logic [2:0] REG_B1_B2       = 3'd2;
	localparam logic [2:0] REG_MC_MD       = 3'd3;
	localparam logic [2:0] REG_OSS         = 3'd4;

	localparam logic [31:0] B6_OFFSET = 32'd4000;
	localparam logic [31:0] B4_BIAS   = 32'd32768;
	localparam logic [31:0] P_C1      = 32'd3038;
	localparam logic [31:0] P_C2      = 32'hFFFF_E343; // -7357
	localparam logic [31:0] P_C3      = 32'd3791;

	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] mc;
		logic [15:0] md;
		logic [1:0]  oss;
	} bpc_cal_t;

	// sideband carried alongside a divide
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        err;
		logic        flag;
	} bpc_side_t;

	// front-to-back queue entry
	typedef struct packed {
		logic [31:0] b5;
		logic [18:0] up;
		logic        err;
	} bpc_entry_t;

	function automatic logic [31:0] sext16(input logic [15:0] v);
		sext16 = {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
		asr = 32'($signed(v) >>> n);
	endfunction

	// 50000 >> oss
	function automatic logic [31:0] b7_scale(input logic [1:0] oss);
		unique case (oss)
			2'd0: b7_scale = 32'd50000;
			2'd1: b7_scale = 32'd25000;
			2'd2: b7_scale = 32'd12500;
			default: b7_scale = 32'd6250;
		endcase
	endfunction

endpackage

### hdl/bpc_div.sv
module bpc_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic                 sgn,
	input  logic [31:0]          num,
	input  logic [31:0]          den,
	input  bpc_pkg::bpc_side_t   side_in,
	output logic                 out_valid,
	output logic [31:0]          quo,
	output bpc_pkg::bpc_side_t   side_out
);

	logic [31:0]        nq_q   [0:32];
	logic [31:0]        rem_q  [0:32];
	logic [31:0]        den_q  [0:32];
	logic               neg_q  [0:32];
	logic               vld_q  [0:32];
	bpc_pkg::bpc_side_t side_q [0:32];

	logic [31:0] nq_n  [0:31];
	logic [31:0] rem_n [0:31];

	logic na, nd;
	assign na = sgn & num[31];
	assign nd = sgn & den[31];

	// one restoring step per stage, quotient bits shift into nq
	always_comb begin
		logic [32:0] trial;
		logic        ge;
		for (int i = 0; i < 32; i++) begin
			trial    = {rem_q[i], nq_q[i][31]};
			ge       = trial >= {1'b0, den_q[i]};
			rem_n[i] = ge ? 32'(trial - {1'b0, den_q[i]}) : trial[31:0];
			nq_n[i]  = {nq_q[i][30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= 32; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 0; i < 32; i++) vld_q[i+1] <= vld_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nq_q[0]   <= na ? 32'(-num) : num;
			den_q[0]  <= nd ? 32'(-den) : den;
			rem_q[0]  <= '0;
			neg_q[0]  <= na ^ nd;
			side_q[0] <= side_in;
			for (int i = 0; i < 32; i++) begin
				nq_q[i+1]   <= nq_n[i];
				rem_q[i+1]  <= rem_n[i];
				den_q[i+1]  <= den_q[i];
				neg_q[i+1]  <= neg_q[i];
				side_q[i+1] <= side_q[i];
			end
		end
	end

	assign out_valid = vld_q[32];
	assign quo       = neg_q[32] ? 32'(-nq_q[32]) : nq_q[32];
	assign side_out  = side_q[32];

endmodule

### hdl/bpc_front.sv
module bpc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpc_pkg::bpc_cal_t     cal,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           ut,
	input  logic [18:0]           up,
	input  logic                  q_full,
	output logic                  push,
	output bpc_pkg::bpc_entry_t   push_data
);

	logic        en;
	logic        v_s1, v_s2;
	logic [15:0] ut_s1;
	logic [18:0] up_s1, up_s2;
	logic [31:0] x1_s2;

	logic               dv;
	logic [31:0]        dq;
	bpc_pkg::bpc_side_t dside_in, dside_out;
	logic [31:0]        tden;

	assign en       = !(dv && q_full);
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ut_s1 <= ut;
			up_s1 <= up;
			up_s2 <= up_s1;
			x1_s2 <= bpc_pkg::asr(32'(({16'd0, ut_s1} - {16'd0, cal.ac6}) * {16'd0, cal.ac5}),
				5'd15);
		end
	end

	assign tden          = x1_s2 + bpc_pkg::sext16(cal.md);
	assign dside_in.a    = x1_s2;
	assign dside_in.b    = {13'd0, up_s2};
	assign dside_in.err  = tden == 32'd0;
	assign dside_in.flag = 1'b0;

	bpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.sgn      (1'b1),
		.num      (bpc_pkg::sext16(cal.mc) << 11),
		.den      (tden),
		.side_in  (dside_in),
		.out_valid(dv),
		.quo      (dq),
		.side_out (dside_out)
	);

	assign push          = dv && !q_full;
	assign push_data.b5  = dside_out.a + dq;
	assign push_data.up  = dside_out.b[18:0];
	assign push_data.err = dside_out.err;

endmodule

### hdl/bpc_queue.sv
module bpc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  bpc_pkg::bpc_entry_t   push_data,
	input  logic                  pop,
	output bpc_pkg::bpc_entry_t   pop_data,
	output logic                  full,
	output logic                  empty
);

	bpc_pkg::bpc_entry_t slot_q [0:3];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full     = cnt_q == 3'd4;
	assign empty    = cnt_q == 3'd0;
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop)  rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end

endmodule

### hdl/bpc_back.sv
module bpc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpc_pkg::bpc_cal_t     cal,
	input  logic                  q_empty,
	output logic                  pop,
	input  bpc_pkg::bpc_entry_t   pop_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           temperature_dc,
	output logic [31:0]           pressure_pa,
	output logic                  div_by_zero
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, out_valid_q;
	logic [31:0] temp_s1, temp_s2, temp_s3, temp_s4, temp_s5, temp_s6;
	logic [31:0] temp_s7, temp_s8, temp_s9;
	logic        err_s1, err_s2, err_s3, err_s4, err_s5, err_s6, err_s7, err_s8, err_s9;
	logic [18:0] up_s1, up_s2, up_s3, up_s4;
	logic [31:0] b6_s1, sq_s2, ac2b6_s2, ac3b6_s2;
	logic [31:0] b2m_s3, b1m_s3, x2a_s3, x1c_s3;
	logic [31:0] b3_s4, x3p_s4;
	logic [31:0] b4_s5, diff_s5;
	logic [31:0] b7_s6, b4_s6;
	logic [31:0] p_s7, p_s8, p_s9, m1_s8, m2_s8, x1_s9, x2_s9;
	logic [31:0] temp_q, pres_q;
	logic        err_q;

	logic [31:0] b6sq, x3, v, x3p, b4;
	logic               dv;
	logic [31:0]        dq;
	bpc_pkg::bpc_side_t dside_in, dside_out;

	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_empty;

	assign b6sq = bpc_pkg::asr(sq_s2, 5'd12);
	assign x3   = bpc_pkg::asr(b2m_s3, 5'd11) + x2a_s3;
	assign v    = ((bpc_pkg::sext16(cal.ac1) << 2) + x3 << cal.oss) + 32'd2;
	assign x3p  = bpc_pkg::asr(x1c_s3 + bpc_pkg::asr(b1m_s3, 5'd16) + 32'd2, 5'd2);
	assign b4   = 32'(b4_s5 * 32'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, out_valid_q} <= '0;
		end else if (en) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= dv;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			out_valid_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b6_s1   <= pop_data.b5 - bpc_pkg::B6_OFFSET;
			temp_s1 <= bpc_pkg::asr(pop_data.b5 + 32'd8, 5'd4);
			err_s1  <= pop_data.err;
			up_s1   <= pop_data.up;

			sq_s2    <= 32'(b6_s1 * b6_s1);
			ac2b6_s2 <= 32'(bpc_pkg::sext16(cal.ac2) * b6_s1);
			ac3b6_s2 <= 32'(bpc_pkg::sext16(cal.ac3) * b6_s1);
			{temp_s2, err_s2, up_s2} <= {temp_s1, err_s1, up_s1};

			b2m_s3 <= 32'(bpc_pkg::sext16(cal.b2) * b6sq);
			b1m_s3 <= 32'(bpc_pkg::sext16(cal.b1) * b6sq);
			x2a_s3 <= bpc_pkg::asr(ac2b6_s2, 5'd11);
			x1c_s3 <= bpc_pkg::asr(ac3b6_s2, 5'd13);
			{temp_s3, err_s3, up_s3} <= {temp_s2, err_s2, up_s2};

			// divide by 4 truncating toward zero
			b3_s4  <= bpc_pkg::asr(v, 5'd2) + 32'(v[31] && (v[1:0] != 2'b00));
			x3p_s4 <= x3p;
			{temp_s4, err_s4, up_s4} <= {temp_s3, err_s3, up_s3};

			b4_s5   <= 32'({16'd0, cal.ac4} * (x3p_s4 + bpc_pkg::B4_BIAS)) >> 15;
			diff_s5 <= {13'd0, up_s4} - b3_s4;
			{temp_s5, err_s5} <= {temp_s4, err_s4};

			b7_s6   <= 32'(diff_s5 * bpc_pkg::b7_scale(cal.oss));
			b4_s6   <= b4;
			temp_s6 <= temp_s5;
			err_s6  <= err_s5 || (b4 == 32'd0);

			p_s7    <= dside_out.flag ? {dq[30:0], 1'b0} : dq;
			temp_s7 <= dside_out.a;
			err_s7  <= dside_out.err;

			m1_s8   <= 32'(bpc_pkg::asr(p_s7, 5'd8) * bpc_pkg::asr(p_s7, 5'd8));
			m2_s8   <= 32'(bpc_pkg::P_C2 * p_s7);
			{p_s8, temp_s8, err_s8} <= {p_s7, temp_s7, err_s7};

			x1_s9   <= bpc_pkg::asr(32'(m1_s8 * bpc_pkg::P_C1), 5'd16);
			x2_s9   <= bpc_pkg::asr(m2_s8, 5'd16);
			{p_s9, temp_s9, err_s9} <= {p_s8, temp_s8, err_s8};

			temp_q <= err_s9 ? 32'd0 : temp_s9;
			pres_q <= err_s9 ? 32'd0 :
				p_s9 + bpc_pkg::asr(x1_s9 + x2_s9 + bpc_pkg::P_C3, 5'd4);
			err_q  <= err_s9;
		end
	end

	assign dside_in.a    = temp_s6;
	assign dside_in.b    = '0;
	assign dside_in.err  = err_s6;
	assign dside_in.flag = b7_s6[31];

	bpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.sgn      (1'b0),
		.num      (b7_s6[31] ? b7_s6 : {b7_s6[30:0], 1'b0}),
		.den      (b4_s6),
		.side_in  (dside_in),
		.out_valid(dv),
		.quo      (dq),
		.side_out (dside_out)
	);

	assign out_valid      = out_valid_q;
	assign temperature_dc = temp_q;
	assign pressure_pa    = pres_q;
	assign div_by_zero    = err_q;

endmodule

### hdl/baro_temp_pressure_compensation.sv
// Barometric temperature/pressure compensation. One raw temperature/pressure pair per
// transfer in, one compensated result per transfer out, in order. Accepts a new pair
// every cycle while the output is drained. Without stalls a result passes through two input
// stages and a 33-register signed divider (temperature term) in the front part, a 4-entry
// queue, then six stages, a 33-register unsigned divider (pressure) and four output stages
// in the back part. Output backpressure stalls the back part; the front keeps running until
// the queue fills. A zero divisor gives div_by_zero = 1 with both results zero. Write
// calibration only while idle.
module baro_temp_pressure_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // ut_raw[15:0], up_raw[34:16], zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // temperature_dc[31:0], pressure_pa[63:32]
	output logic        m_axis_tuser   // div_by_zero
);

	logic [47:0] ac123_q, ac456_q;
	logic [31:0] b12_q, mcmd_q;
	logic [1:0]  oss_q;
	bpc_pkg::bpc_cal_t   cal;
	logic                push, pop, q_full, q_empty;
	bpc_pkg::bpc_entry_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac123_q <= '0;
			ac456_q <= '0;
			b12_q   <= '0;
			mcmd_q  <= '0;
			oss_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpc_pkg::REG_AC1_AC2_AC3: ac123_q <= cfg_wdata;
				bpc_pkg::REG_AC4_AC5_AC6: ac456_q <= cfg_wdata;
				bpc_pkg::REG_B1_B2:       b12_q   <= cfg_wdata[31:0];
				bpc_pkg::REG_MC_MD:       mcmd_q  <= cfg_wdata[31:0];
				bpc_pkg::REG_OSS:         oss_q   <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	assign cal.ac1 = ac123_q[15:0];
	assign cal.ac2 = ac123_q[31:16];
	assign cal.ac3 = ac123_q[47:32];
	assign cal.ac4 = ac456_q[15:0];
	assign cal.ac5 = ac456_q[31:16];
	assign cal.ac6 = ac456_q[47:32];
	assign cal.b1  = b12_q[15:0];
	assign cal.b2  = b12_q[31:16];
	assign cal.mc  = mcmd_q[15:0];
	assign cal.md  = mcmd_q[31:16];
	assign cal.oss = oss_q;

	bpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cal      (cal),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.ut       (s_axis_tdata[15:0]),
		.up       (s_axis_tdata[34:16]),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	bpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	bpc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cal           (cal),
		.q_empty       (q_empty),
		.pop           (pop),
		.pop_data      (pop_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.temperature_dc(m_axis_tdata[31:0]),
		.pressure_pa   (m_axis_tdata[63:32]),
		.div_by_zero   (m_axis_tuser)
	);

endmodule
